/* sv/tla_pkg.sv */
package tla_pkg;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] command_byte;
    logic       connected;
    logic       rx_valid;
    logic [6:0] rx_char;
    logic       rx_break;
    logic [7:0] channel_byte;
    logic       channel_stop;
    logic       rx_pending;
  } in_t;

  typedef struct packed {
    logic [7:0] immediate_status;
    logic [1:0] cond_code;
    logic       end_valid;
    logic [7:0] end_status;
    logic       chan_out_valid;
    logic [7:0] chan_out_byte;
    logic       tx_valid;
    logic [6:0] tx_char;
    logic [7:0] erase_count;
    logic       attention;
    logic [2:0] line_action;
    logic [2:0] resched_last;
  } out_t;

  typedef struct packed {
    logic [7:0] cmd;
    logic [7:0] mode;
    logic [7:0] sense;
  } ctl_t;

  localparam int MAX_RES = 4;

  localparam logic [2:0] FN_START   = 3'd0;
  localparam logic [2:0] FN_HALT    = 3'd1;
  localparam logic [2:0] FN_SERVICE = 3'd2;
  localparam logic [2:0] FN_CONNECT = 3'd3;
  localparam logic [2:0] FN_SCAN    = 3'd4;

  localparam logic [7:0] CMD_NONE      = 8'h00;
  localparam logic [7:0] CMD_WRITE     = 8'h01;
  localparam logic [7:0] CMD_READ      = 8'h02;
  localparam logic [7:0] CMD_DIAL_CODE = 8'h03;
  localparam logic [7:0] CMD_SENSE     = 8'h04;
  localparam logic [7:0] CMD_PREPARE   = 8'h06;
  localparam logic [7:0] CMD_READ_INH  = 8'h0A;
  localparam logic [7:0] CMD_ADDR_PREP = 8'h0D;
  localparam logic [7:0] CMD_BREAK     = 8'h0E;
  localparam logic [7:0] CMD_ENABLE    = 8'h27;
  localparam logic [7:0] CMD_DIAL      = 8'h29;
  localparam logic [7:0] CMD_DISABLE   = 8'h2F;

  localparam logic [7:0] ST_BUSY = 8'h10;
  localparam logic [7:0] ST_CE   = 8'h08;
  localparam logic [7:0] ST_DE   = 8'h04;
  localparam logic [7:0] ST_UC   = 8'h02;
  localparam logic [7:0] ST_UE   = 8'h01;

  localparam logic [7:0] SN_NONE    = 8'h00;
  localparam logic [7:0] SN_CMDREJ  = 8'h80;
  localparam logic [7:0] SN_INTVENT = 8'h40;

  localparam logic [7:0] M_RECV   = 8'h01;
  localparam logic [7:0] M_ENAB   = 8'h02;
  localparam logic [7:0] M_POLL   = 8'h04;
  localparam logic [7:0] M_ADDR   = 8'h08;
  localparam logic [7:0] M_INPUT  = 8'h10;
  localparam logic [7:0] M_ADDR9  = 8'h20;
  localparam logic [7:0] M_BYPASS = 8'h40;
  localparam logic [7:0] M_BREAK  = 8'h80;

  localparam logic [7:0] TC_NL      = 8'h5b;
  localparam logic [7:0] TC_EOA     = 8'h1f;
  localparam logic [7:0] TC_EOT     = 8'h16;
  localparam logic [7:0] TC_BYPASS  = 8'hb8;
  localparam logic [7:0] TC_RESTORE = 8'h58;
  localparam logic [7:0] TC_ADDR9   = 8'h13;
  localparam logic [7:0] TC_NL_UC   = 8'hdb;

  localparam logic [6:0] CH_ETX = 7'h03;
  localparam logic [6:0] CH_BS  = 7'h08;
  localparam logic [6:0] CH_LF  = 7'h0A;
  localparam logic [6:0] CH_CR  = 7'h0D;
  localparam logic [6:0] CH_NAK = 7'h15;
  localparam logic [6:0] CH_DEL = 7'h7F;

  localparam logic [1:0] CC_DONE    = 2'd1;
  localparam logic [1:0] CC_NOT_ATT = 2'd3;

  localparam logic [2:0] LA_NONE      = 3'd0;
  localparam logic [2:0] LA_RAISE_DTR = 3'd1;
  localparam logic [2:0] LA_DROP_DTR  = 3'd2;
  localparam logic [2:0] LA_RESET     = 3'd3;
  localparam logic [2:0] LA_RX_ENABLE = 3'd4;

  localparam logic [1:0] RS_NONE  = 2'd0;
  localparam logic [1:0] RS_SHORT = 2'd1;
  localparam logic [1:0] RS_LONG  = 2'd2;

  localparam logic [2:0] REG_ATTACHED = 3'd0;
  localparam logic [2:0] REG_DIRECT   = 3'd4;

  function automatic logic [7:0] asc_to_term(input logic [6:0] c);
    logic [7:0] t;
    case (c)
      7'h08: t = 8'hDD; 7'h09: t = 8'hFA; 7'h0A: t = 8'hB5; 7'h0D: t = 8'h5B;
      7'h20: t = 8'h81; 7'h21: t = 8'hD7; 7'h22: t = 8'h96; 7'h23: t = 8'h16;
      7'h24: t = 8'h57; 7'h25: t = 8'h8B; 7'h26: t = 8'h61; 7'h27: t = 8'h8D;
      7'h28: t = 8'h93; 7'h29: t = 8'h95; 7'h2A: t = 8'h90; 7'h2B: t = 8'hE1;
      7'h2C: t = 8'h37; 7'h2D: t = 8'hC0; 7'h2E: t = 8'h76; 7'h2F: t = 8'h23;
      7'h30: t = 8'h15; 7'h31: t = 8'h02; 7'h32: t = 8'h04; 7'h33: t = 8'h07;
      7'h34: t = 8'h08; 7'h35: t = 8'h0B; 7'h36: t = 8'h0D; 7'h37: t = 8'h0E;
      7'h38: t = 8'h10; 7'h39: t = 8'h13; 7'h3A: t = 8'h88; 7'h3B: t = 8'h87;
      7'h3C: t = 8'h84; 7'h3D: t = 8'h82; 7'h3E: t = 8'h8E; 7'h3F: t = 8'hA3;
      7'h40: t = 8'h20; 7'h41: t = 8'hE2; 7'h42: t = 8'hE4; 7'h43: t = 8'hE7;
      7'h44: t = 8'hE8; 7'h45: t = 8'hEB; 7'h46: t = 8'hED; 7'h47: t = 8'hEE;
      7'h48: t = 8'hF0; 7'h49: t = 8'hF3; 7'h4A: t = 8'hC3; 7'h4B: t = 8'hC5;
      7'h4C: t = 8'hC6; 7'h4D: t = 8'hC9; 7'h4E: t = 8'hCA; 7'h4F: t = 8'hCC;
      7'h50: t = 8'hCF; 7'h51: t = 8'hD1; 7'h52: t = 8'hD2; 7'h53: t = 8'hA5;
      7'h54: t = 8'hA6; 7'h55: t = 8'hA9; 7'h56: t = 8'hAA; 7'h57: t = 8'hAC;
      7'h58: t = 8'hAF; 7'h59: t = 8'hB1; 7'h5A: t = 8'hB2; 7'h5F: t = 8'h40;
      7'h61: t = 8'h62; 7'h62: t = 8'h64; 7'h63: t = 8'h67; 7'h64: t = 8'h68;
      7'h65: t = 8'h6B; 7'h66: t = 8'h6D; 7'h67: t = 8'h6E; 7'h68: t = 8'h70;
      7'h69: t = 8'h73; 7'h6A: t = 8'h43; 7'h6B: t = 8'h45; 7'h6C: t = 8'h46;
      7'h6D: t = 8'h49; 7'h6E: t = 8'h4A; 7'h6F: t = 8'h4C; 7'h70: t = 8'h4F;
      7'h71: t = 8'h51; 7'h72: t = 8'h52; 7'h73: t = 8'h25; 7'h74: t = 8'h26;
      7'h75: t = 8'h29; 7'h76: t = 8'h2A; 7'h77: t = 8'h2C; 7'h78: t = 8'h2F;
      7'h79: t = 8'h31; 7'h7A: t = 8'h32; 7'h7C: t = 8'hB7; 7'h7E: t = 8'hF6;
      default: t = 8'h00;
    endcase
    return t;
  endfunction

  function automatic logic [6:0] term_to_asc(input logic [7:0] ch);
    logic [6:0] a;
    case (ch)
      8'h01: a = 7'h20; 8'h02: a = 7'h31; 8'h04: a = 7'h32; 8'h07: a = 7'h33;
      8'h08: a = 7'h34; 8'h0B: a = 7'h35; 8'h0D: a = 7'h36; 8'h0E: a = 7'h37;
      8'h10: a = 7'h38; 8'h13: a = 7'h39; 8'h15: a = 7'h30; 8'h16: a = 7'h23;
      8'h20: a = 7'h40; 8'h23: a = 7'h2F; 8'h25: a = 7'h73; 8'h26: a = 7'h74;
      8'h29: a = 7'h75; 8'h2A: a = 7'h76; 8'h2C: a = 7'h77; 8'h2F: a = 7'h78;
      8'h31: a = 7'h79; 8'h32: a = 7'h7A; 8'h37: a = 7'h2C;
      8'h40: a = 7'h5F; 8'h43: a = 7'h6A; 8'h45: a = 7'h6B; 8'h46: a = 7'h6C;
      8'h49: a = 7'h6D; 8'h4A: a = 7'h6E; 8'h4C: a = 7'h6F; 8'h4F: a = 7'h70;
      8'h51: a = 7'h71; 8'h52: a = 7'h72; 8'h57: a = 7'h24; 8'h5B: a = 7'h0A;
      8'h5D: a = 7'h08;
      8'h61: a = 7'h26; 8'h62: a = 7'h61; 8'h64: a = 7'h62; 8'h67: a = 7'h63;
      8'h68: a = 7'h64; 8'h6B: a = 7'h65; 8'h6D: a = 7'h66; 8'h6E: a = 7'h67;
      8'h70: a = 7'h68; 8'h73: a = 7'h69; 8'h76: a = 7'h2E; 8'h7A: a = 7'h09;
      8'h7F: a = 7'h7F;
      8'h81: a = 7'h20; 8'h82: a = 7'h3D; 8'h84: a = 7'h3C; 8'h87: a = 7'h3B;
      8'h88: a = 7'h3A; 8'h8B: a = 7'h25; 8'h8D: a = 7'h27; 8'h8E: a = 7'h3E;
      8'h90: a = 7'h2A; 8'h93: a = 7'h28; 8'h95: a = 7'h29; 8'h96: a = 7'h22;
      8'hA3: a = 7'h3F; 8'hA5: a = 7'h53; 8'hA6: a = 7'h54; 8'hA9: a = 7'h55;
      8'hAA: a = 7'h56; 8'hAC: a = 7'h57; 8'hAF: a = 7'h58;
      8'hB1: a = 7'h59; 8'hB2: a = 7'h5A; 8'hB7: a = 7'h7C;
      8'hC0: a = 7'h2D; 8'hC1: a = 7'h2D; 8'hC3: a = 7'h4A; 8'hC5: a = 7'h4B;
      8'hC6: a = 7'h4C; 8'hC9: a = 7'h4D; 8'hCA: a = 7'h4E; 8'hCC: a = 7'h4F;
      8'hCF: a = 7'h50;
      8'hD1: a = 7'h51; 8'hD2: a = 7'h52; 8'hD7: a = 7'h21; 8'hDB: a = 7'h0A;
      8'hDD: a = 7'h08;
      8'hE1: a = 7'h2B; 8'hE2: a = 7'h41; 8'hE4: a = 7'h42; 8'hE7: a = 7'h43;
      8'hE8: a = 7'h44; 8'hEB: a = 7'h45; 8'hED: a = 7'h46; 8'hEE: a = 7'h47;
      8'hF0: a = 7'h48; 8'hF3: a = 7'h49; 8'hF6: a = 7'h7E; 8'hFA: a = 7'h09;
      8'hFF: a = 7'h7F;
      default: a = 7'h00;
    endcase
    return a;
  endfunction

endpackage

/* sv/tla_ram.sv */
module tla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/tla_engine.sv */
module tla_engine #(
  parameter int BUFFER_DEPTH = 256,
  parameter int PTR_W        = $clog2(BUFFER_DEPTH)
) (
  input  tla_pkg::in_t       item,
  input  logic               attached,
  input  logic               direct_line,
  input  tla_pkg::ctl_t      ctl,
  input  logic [PTR_W-1:0]   fill,
  input  logic [PTR_W-1:0]   drain,
  input  logic [7:0]         rdata,
  output tla_pkg::ctl_t      ctl_nxt,
  output logic [PTR_W-1:0]   fill_nxt,
  output logic [PTR_W-1:0]   drain_nxt,
  output tla_pkg::out_t      res [tla_pkg::MAX_RES],
  output logic [2:0]         nres,
  output logic               wr0_en,
  output logic [PTR_W-1:0]   wr0_addr,
  output logic [7:0]         wr0_data,
  output logic               wr1_en,
  output logic [PTR_W-1:0]   wr1_addr
);
  import tla_pkg::*;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  logic [7:0] imm, ends, chb, term;
  logic [1:0] cc, resched, erase_k, last_k;
  logic       endv, chv, att, do_rcv, erase_en;
  logic [2:0] la, ntx;
  logic [7:0] erase_val;
  logic [6:0] txc [MAX_RES];
  logic [6:0] wasc;

  always_comb begin
    ctl_nxt   = ctl;
    fill_nxt  = fill;
    drain_nxt = drain;
    imm = '0; cc = '0; endv = 1'b0; ends = '0; chv = 1'b0; chb = '0;
    att = 1'b0; la = LA_NONE; resched = RS_NONE; do_rcv = 1'b0;
    ntx = '0; erase_en = 1'b0; erase_val = '0; erase_k = '0;
    for (int i = 0; i < MAX_RES; i++) txc[i] = '0;
    wr0_en = 1'b0; wr0_addr = fill; wr0_data = '0; wr1_en = 1'b0; wr1_addr = '0;
    term = '0;
    wasc = term_to_asc(item.channel_byte);

    unique case (item.func)
      FN_START: begin
        if (ctl.cmd != CMD_NONE) begin
          imm = ST_BUSY;
        end else if (item.command_byte[1:0] == 2'b11 &&
                     (item.command_byte == CMD_DIAL_CODE || item.command_byte[4])) begin
          imm = ST_CE | ST_DE;
        end else if (item.command_byte[1:0] != 2'b00) begin
          ctl_nxt.cmd = item.command_byte;
          ctl_nxt.sense = SN_NONE;
          resched = RS_SHORT;
        end else if (item.command_byte == CMD_SENSE) begin
          ctl_nxt.cmd = item.command_byte;
          resched = RS_SHORT;
        end else begin
          imm = ST_CE | ST_DE | ((ctl.sense != SN_NONE) ? ST_UC : 8'h00);
        end
      end
      FN_HALT: begin
        if (!attached) begin
          cc = CC_NOT_ATT;
        end else begin
          cc = CC_DONE;
          case (ctl.cmd) inside
            CMD_PREPARE: begin
              ctl_nxt.mode = ctl.mode & ~(M_ADDR9 | M_ADDR);
              ctl_nxt.cmd = CMD_NONE;
              endv = 1'b1; ends = ST_CE | ST_DE | ST_UE;
            end
            CMD_READ_INH, CMD_READ, CMD_WRITE, CMD_ADDR_PREP, CMD_BREAK: begin
              ctl_nxt.mode = ctl.mode & ~(M_ADDR9 | M_ADDR);
              ctl_nxt.cmd = CMD_NONE;
              endv = 1'b1; ends = ST_CE | ST_DE;
            end
            CMD_ENABLE: begin
              ctl_nxt.mode = ctl.mode & ~(M_POLL | M_ADDR9 | M_ADDR);
              ctl_nxt.cmd = CMD_NONE;
              la = LA_RESET;
              endv = 1'b1; ends = ST_CE | ST_DE | ST_UE;
            end
            default: ;
          endcase
        end
      end
      FN_SERVICE: begin
        do_rcv = 1'b1;
        case (ctl.cmd) inside
          CMD_SENSE: begin
            chv = 1'b1; chb = ctl.sense;
            ctl_nxt.cmd = CMD_NONE;
            endv = 1'b1; ends = ST_CE | ST_DE;
          end
          CMD_DIAL: begin
            ctl_nxt.sense = SN_CMDREJ;
            endv = 1'b1; ends = ST_CE | ST_DE | ST_UC;
          end
          CMD_READ, CMD_READ_INH: begin
            ctl_nxt.sense = SN_NONE;
            if ((ctl.mode & M_ENAB) == 8'h00) begin
              ctl_nxt.cmd = CMD_NONE;
              endv = 1'b1; ends = ST_CE | ST_DE | ST_UE;
            end else begin
              ctl_nxt.mode = ctl.mode | M_RECV;
              if (!item.connected) begin
                ctl_nxt.cmd = CMD_NONE;
                ctl_nxt.mode = ctl_nxt.mode &
                               ~(M_BREAK | M_INPUT | M_ENAB | M_POLL | M_RECV);
                ctl_nxt.sense = SN_INTVENT;
                fill_nxt = '0; drain_nxt = '0;
                endv = 1'b1; ends = ST_CE | ST_DE | ST_UE;
                do_rcv = 1'b0;
              end else if ((ctl_nxt.mode & M_ADDR) != 8'h00 && fill == '0) begin
                ctl_nxt.mode = ctl_nxt.mode & ~M_ADDR;
                chv = 1'b1; chb = TC_EOT;
                if (item.channel_stop || (ctl_nxt.mode & M_ADDR9) != 8'h00) begin
                  ctl_nxt.mode = ctl_nxt.mode & ~M_ADDR9;
                  ctl_nxt.cmd = CMD_NONE;
                  endv = 1'b1; ends = ST_CE | ST_DE;
                  do_rcv = 1'b0;
                end else begin
                  resched = RS_SHORT;
                end
              end else if ((ctl_nxt.mode & M_BREAK) != 8'h00) begin
                ctl_nxt.cmd = CMD_NONE;
                ctl_nxt.mode = ctl_nxt.mode & ~(M_BREAK | M_INPUT | M_RECV);
                ctl_nxt.sense = SN_INTVENT;
                fill_nxt = '0; drain_nxt = '0;
                endv = 1'b1; ends = ST_CE | ST_DE | ST_UC | ST_UE;
                do_rcv = 1'b0;
              end else if ((ctl_nxt.mode & M_INPUT) != 8'h00) begin
                if (fill != drain) begin
                  drain_nxt = bump(drain);
                  chv = 1'b1; chb = rdata;
                end
                if (fill == drain || item.channel_stop) begin
                  ctl_nxt.cmd = CMD_NONE;
                  ctl_nxt.mode = ctl_nxt.mode & ~(M_INPUT | M_RECV);
                  fill_nxt = '0; drain_nxt = '0;
                  endv = 1'b1; ends = ST_CE | ST_DE;
                  do_rcv = 1'b0;
                end else begin
                  resched = RS_SHORT;
                end
              end else begin
                resched = RS_SHORT;
              end
            end
          end
          CMD_WRITE: begin
            ctl_nxt.sense = SN_NONE;
            if ((ctl.mode & M_ENAB) == 8'h00) begin
              ctl_nxt.cmd = CMD_NONE;
              endv = 1'b1; ends = ST_CE | ST_DE | ST_UE;
            end else if (!item.connected) begin
              ctl_nxt.cmd = CMD_NONE;
              ctl_nxt.mode = ctl.mode & ~(M_BREAK | M_INPUT | M_ENAB | M_POLL);
              ctl_nxt.sense = SN_INTVENT;
              fill_nxt = '0; drain_nxt = '0;
              endv = 1'b1; ends = ST_CE | ST_DE | ST_UE;
              do_rcv = 1'b0;
            end else if ((ctl.mode & M_BREAK) != 8'h00) begin
              ctl_nxt.cmd = CMD_NONE;
              ctl_nxt.mode = ctl.mode & ~M_BREAK;
              ctl_nxt.sense = SN_INTVENT;
              endv = 1'b1; ends = ST_CE | ST_DE | ST_UC;
              do_rcv = 1'b0;
            end else if (item.channel_stop) begin
              ctl_nxt.cmd = CMD_NONE;
              endv = 1'b1; ends = ST_CE | ST_DE;
            end else begin
              if (item.channel_byte == TC_EOA) begin
                ctl_nxt.mode = ctl.mode | M_ADDR;
              end else if (item.channel_byte == TC_EOT) begin
                ctl_nxt.mode = ctl.mode & ~M_ADDR;
              end else if (item.channel_byte == TC_BYPASS) begin
                ctl_nxt.mode = ctl.mode | M_BYPASS;
              end else if (item.channel_byte == TC_RESTORE) begin
                ctl_nxt.mode = ctl.mode & ~(M_BYPASS | M_ADDR | M_ADDR9);
              end else if ((ctl.mode & M_ADDR) != 8'h00 && item.channel_byte == TC_ADDR9) begin
                ctl_nxt.mode = ctl.mode | M_ADDR9;
              end else if ((ctl.mode & M_ADDR) == 8'h00 && wasc != 7'h00) begin
                txc[ntx[1:0]] = wasc;
                ntx = ntx + 3'd1;
                if (item.channel_byte == TC_NL || item.channel_byte == TC_NL_UC) begin
                  txc[ntx[1:0]] = CH_CR;
                  ntx = ntx + 3'd1;
                end
              end
              resched = RS_LONG;
            end
          end
          CMD_ADDR_PREP: begin
            ctl_nxt.cmd = CMD_NONE;
            ctl_nxt.mode = ctl.mode | M_ADDR;
            ctl_nxt.sense = SN_NONE;
            endv = 1'b1; ends = ST_CE | ST_DE;
          end
          CMD_PREPARE: begin
            ctl_nxt.sense = SN_NONE;
            if ((ctl.mode & M_ENAB) == 8'h00) begin
              ctl_nxt.cmd = CMD_NONE;
              endv = 1'b1; ends = ST_CE | ST_DE | ST_UE;
            end else if (!item.connected) begin
              ctl_nxt.cmd = CMD_NONE;
              ctl_nxt.mode = ctl.mode & ~(M_BREAK | M_INPUT | M_ENAB | M_POLL);
              ctl_nxt.sense = SN_INTVENT;
              fill_nxt = '0; drain_nxt = '0;
              endv = 1'b1; ends = ST_CE | ST_DE | ST_UE;
              do_rcv = 1'b0;
            end else begin
              ctl_nxt.mode = (ctl.mode | M_RECV) & ~(M_ADDR | M_ADDR9);
              if ((ctl_nxt.mode & (M_INPUT | M_BREAK)) != 8'h00) begin
                ctl_nxt.cmd = CMD_NONE;
                endv = 1'b1; ends = ST_CE | ST_DE;
              end else begin
                resched = RS_SHORT;
              end
            end
          end
          CMD_BREAK: begin
            ctl_nxt.cmd = CMD_NONE;
            ctl_nxt.sense = SN_NONE;
            endv = 1'b1; ends = ST_CE | ST_DE;
          end
          CMD_ENABLE: begin
            ctl_nxt.sense = SN_NONE;
            if ((ctl.mode & (M_POLL | M_ENAB)) == M_ENAB) begin
              ctl_nxt.cmd = CMD_NONE;
              fill_nxt = '0; drain_nxt = '0;
              endv = 1'b1; ends = ST_CE | ST_DE;
            end else if ((ctl.mode & M_POLL) == 8'h00) begin
              la = LA_RAISE_DTR;
              ctl_nxt.mode = ctl.mode | M_POLL;
            end
          end
          CMD_DISABLE: begin
            ctl_nxt.sense = SN_NONE;
            la = LA_DROP_DTR;
            ctl_nxt.cmd = CMD_NONE;
            ctl_nxt.mode = ctl.mode & ~(M_POLL | M_ENAB);
            endv = 1'b1; ends = ST_CE | ST_DE;
          end
          default: ;
        endcase
      end
      FN_CONNECT: begin
        if (attached && (ctl.mode & M_ENAB) == 8'h00) begin
          if ((ctl.mode & M_POLL) == 8'h00) begin
            if (direct_line) begin
              att = 1'b1;
              ctl_nxt.mode = ctl.mode | M_ENAB | M_ADDR;
              la = LA_RX_ENABLE;
              resched = RS_SHORT;
            end else begin
              la = LA_DROP_DTR;
            end
          end else begin
            la = LA_RX_ENABLE;
            ctl_nxt.mode = (ctl.mode & ~M_POLL) | M_ENAB;
            resched = RS_SHORT;
          end
        end
      end
      FN_SCAN: begin
        if (attached && (ctl.mode & (M_RECV | M_ENAB)) == M_ENAB && item.rx_pending) begin
          att = 1'b1;
        end
      end
      default: ;
    endcase

    // line receive path, after the command has had its turn
    if (do_rcv && (ctl_nxt.mode & (M_ENAB | M_RECV)) == (M_ENAB | M_RECV) &&
        item.rx_valid) begin
      if (item.rx_break) begin
        ctl_nxt.mode = ctl_nxt.mode | M_BREAK;
      end else begin
        term = asc_to_term(item.rx_char);
        case (item.rx_char) inside
          CH_CR, CH_LF: begin
            wr0_en = 1'b1; wr0_addr = fill_nxt; wr0_data = TC_NL;
            wr1_en = 1'b1; wr1_addr = bump(fill_nxt);
            fill_nxt = bump(bump(fill_nxt));
            ctl_nxt.mode = (ctl_nxt.mode | M_INPUT) & ~M_RECV;
            drain_nxt = '0;
            txc[ntx[1:0]] = CH_CR;
            ntx = ntx + 3'd1;
            txc[ntx[1:0]] = CH_LF;
            ntx = ntx + 3'd1;
          end
          CH_DEL, CH_BS: begin
            if (fill_nxt != '0) begin
              fill_nxt = fill_nxt - 1'b1;
              erase_en = 1'b1; erase_val = 8'd1;
              erase_k = (ntx == 3'd0) ? 2'd0 : 2'(ntx - 3'd1);
            end
          end
          CH_NAK: begin
            erase_en = 1'b1; erase_val = 8'(fill_nxt);
            erase_k = (ntx == 3'd0) ? 2'd0 : 2'(ntx - 3'd1);
            fill_nxt = '0;
          end
          CH_ETX: begin
            ctl_nxt.mode = (ctl_nxt.mode | M_BREAK) & ~M_RECV;
          end
          default: begin
            if (fill_nxt < PTR_W'(BUFFER_DEPTH - 3)) begin
              if (term != 8'h00) begin
                wr0_en = 1'b1; wr0_addr = fill_nxt; wr0_data = term;
                fill_nxt = bump(fill_nxt);
                if ((ctl_nxt.mode & M_BYPASS) == 8'h00) begin
                  txc[ntx[1:0]] = item.rx_char;
                  ntx = ntx + 3'd1;
                end
              end
            end else begin
              wr0_en = 1'b1; wr0_addr = fill_nxt; wr0_data = TC_NL;
              wr1_en = 1'b1; wr1_addr = bump(fill_nxt);
              fill_nxt = bump(bump(fill_nxt));
              ctl_nxt.mode = (ctl_nxt.mode | M_INPUT) & ~M_RECV;
            end
          end
        endcase
      end
    end

    nres = (ntx == 3'd0) ? 3'd1 : ntx;
    last_k = 2'(nres - 3'd1);
    for (int i = 0; i < MAX_RES; i++) begin
      res[i] = '0;
      res[i].tx_valid = (3'(i) < ntx);
      res[i].tx_char = (3'(i) < ntx) ? txc[i] : 7'h00;
      if (erase_en && erase_k == 2'(i)) res[i].erase_count = erase_val;
      if (last_k == 2'(i)) res[i].resched_last = {resched, 1'b1};
    end
    res[0].immediate_status = imm;
    res[0].cond_code = cc;
    res[0].end_valid = endv;
    res[0].end_status = ends;
    res[0].chan_out_valid = chv;
    res[0].chan_out_byte = chb;
    res[0].attention = att;
    res[0].line_action = la;
  end

endmodule

/* sv/terminal_line_adapter.sv */
// channel | ports                               | direction | transfer
// in      | in_valid in_ready in_data           | input     | one event request
// out     | out_valid out_ready out_data        | output    | one result request
// cfg     | cfg_psel cfg_penable cfg_pwrite ... | input     | register write and read
//
// on each event, the accept cycle reads the receive buffer at the drain pointer;
// the update step then updates state and writes the buffer (a second buffer
// write, when the line closes, lands in the following cycle)
// an event yields one to four results, delivered one per cycle while out_ready is high, from a result set;
// the update step waits while the previous result set is still being taken
// reset is synchronous; the receive buffer is not cleared and needs no sweep
module terminal_line_adapter #(
  parameter int BUFFER_DEPTH = 256
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  tla_pkg::in_t    in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output tla_pkg::out_t   out_data,
  input  logic            cfg_psel,
  input  logic            cfg_penable,
  input  logic            cfg_pwrite,
  input  logic [2:0]      cfg_paddr,
  input  logic [31:0]     cfg_pwdata,
  output logic [31:0]     cfg_prdata,
  output logic            cfg_pready
);
  import tla_pkg::*;

  localparam int PTR_W = $clog2(BUFFER_DEPTH);

  logic             busy_r;
  in_t              item_r;
  ctl_t             ctl_r, ctl_nxt;
  logic [PTR_W-1:0] fill_r, fill_nxt, drain_r, drain_nxt;
  logic             attached_r, direct_r;
  logic             pend_we_r;
  logic [PTR_W-1:0] pend_addr_r;
  logic             fwd_hit_r;
  out_t             res_r [MAX_RES];
  out_t             res_nxt [MAX_RES];
  logic [2:0]       nres_r, nres_nxt;
  logic [1:0]       idx_r;

  logic             accept, out_take, last_take, slot_free, fire;
  logic             wr0_en, wr1_en, ram_we;
  logic [PTR_W-1:0] wr0_addr, wr1_addr, ram_waddr;
  logic [7:0]       wr0_data, ram_wdata, ram_rdata, rdata_eff;
  logic             cfg_wr;

  assign in_ready  = !busy_r;
  assign accept    = in_valid && in_ready;
  assign out_valid = (nres_r != 3'd0);
  assign out_data  = res_r[idx_r];
  assign out_take  = out_valid && out_ready;
  assign last_take = out_take && ({1'b0, idx_r} == nres_r - 3'd1);
  assign slot_free = (nres_r == 3'd0) || last_take;
  assign fire      = busy_r && slot_free;
  assign rdata_eff = fwd_hit_r ? TC_EOA : ram_rdata;

  // closing write pair: second entry goes out in the cycle after
  always_comb begin
    if (fire && wr0_en) begin
      ram_we = 1'b1; ram_waddr = wr0_addr; ram_wdata = wr0_data;
    end else begin
      ram_we = pend_we_r; ram_waddr = pend_addr_r; ram_wdata = TC_EOA;
    end
  end

  tla_ram #(.WIDTH(8), .DEPTH(BUFFER_DEPTH)) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (drain_r),
    .rdata (ram_rdata)
  );

  tla_engine #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_engine (
    .item        (item_r),
    .attached    (attached_r),
    .direct_line (direct_r),
    .ctl         (ctl_r),
    .fill        (fill_r),
    .drain       (drain_r),
    .rdata       (rdata_eff),
    .ctl_nxt     (ctl_nxt),
    .fill_nxt    (fill_nxt),
    .drain_nxt   (drain_nxt),
    .res         (res_nxt),
    .nres        (nres_nxt),
    .wr0_en      (wr0_en),
    .wr0_addr    (wr0_addr),
    .wr0_data    (wr0_data),
    .wr1_en      (wr1_en),
    .wr1_addr    (wr1_addr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      ctl_r     <= '0;
      fill_r    <= '0;
      drain_r   <= '0;
      pend_we_r <= 1'b0;
      fwd_hit_r <= 1'b0;
      nres_r    <= '0;
      idx_r     <= '0;
    end else begin
      pend_we_r <= 1'b0;
      if (accept) begin
        busy_r    <= 1'b1;
        fwd_hit_r <= pend_we_r && (pend_addr_r == drain_r);
      end
      if (fire) begin
        busy_r    <= 1'b0;
        ctl_r     <= ctl_nxt;
        fill_r    <= fill_nxt;
        drain_r   <= drain_nxt;
        pend_we_r <= wr1_en;
        nres_r    <= nres_nxt;
        idx_r     <= '0;
      end else if (last_take) begin
        nres_r <= '0;
        idx_r  <= '0;
      end else if (out_take) begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) item_r <= in_data;
    if (fire) begin
      pend_addr_r <= wr1_addr;
      for (int i = 0; i < MAX_RES; i++) res_r[i] <= res_nxt[i];
    end
  end

  // register port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attached_r <= 1'b0;
      direct_r   <= 1'b0;
    end else if (cfg_wr) begin
      unique case ({cfg_paddr[2], 2'b00})
        REG_ATTACHED: attached_r <= cfg_pwdata[0];
        REG_DIRECT:   direct_r   <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case ({cfg_paddr[2], 2'b00})
      REG_ATTACHED: cfg_prdata = {31'b0, attached_r};
      REG_DIRECT:   cfg_prdata = {31'b0, direct_r};
      default:      cfg_prdata = '0;
    endcase
  end

`ifndef SYNTH
  a_pend_after_fire: assert property (@(posedge clk) disable iff (!rst_n)
    pend_we_r |-> !busy_r)
    else $error("pending buffer write overlaps an event in progress");

  a_res_count: assert property (@(posedge clk) disable iff (!rst_n)
    nres_r <= 3'd4)
    else $error("result set count out of range");

  a_idx_in_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, idx_r} < nres_r))
    else $error("result index beyond result set");
`endif

endmodule
